// ===== src/cstp_pkg.sv =====
// Shared types and constants of the call-stack time profiler.
// No dependencies; cstp_front, cstp_back, the top level and the testbench import this package.
`timescale 1ns / 1ps

package cstp_pkg;

    localparam int FID_W    = 8;
    localparam int TS_W     = 32;
    localparam int CALLS_W  = 32;
    localparam int TOTAL_W  = 48;
    localparam int DEPTH_W  = 7;
    localparam int LEVEL_W  = 7;
    localparam int STATUS_W = 3;
    localparam int KIND_W   = 2;
    localparam int FID_COUNT = 2 ** FID_W;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 7'd127;

    typedef enum logic [KIND_W-1:0] {
        KIND_ENTER = 2'd0,
        KIND_LEAVE = 2'd1,
        KIND_READ  = 2'd2,
        KIND_CLEAR = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK            = 3'd0,
        STAT_NOT_CAPTURING = 3'd1,
        STAT_STACK_EMPTY   = 3'd2,
        STAT_MISMATCH      = 3'd3,
        STAT_STACK_FULL    = 3'd4
    } status_t;

    // Item class decided by the front end.
    typedef enum logic [2:0] {
        CLS_ENTER = 3'd0,
        CLS_LEAVE = 3'd1,
        CLS_READ  = 3'd2,
        CLS_CLEAR = 3'd3,
        CLS_NOCAP = 3'd4
    } cls_t;

    typedef enum logic [2:0] {
        BK_SWEEP = 3'd0,
        BK_IDLE  = 3'd1,
        BK_WAIT  = 3'd2,
        BK_CALC  = 3'd3,
        BK_EXEC  = 3'd4
    } back_state_t;

    typedef struct packed {
        cls_t             cls;
        logic [FID_W-1:0] fid;
        logic [TS_W-1:0]  ts;
    } op_t;

    typedef struct packed {
        logic               valid;
        logic [CALLS_W-1:0] calls;
        logic [TOTAL_W-1:0] incl;
        logic [TOTAL_W-1:0] excl;
        logic [DEPTH_W-1:0] depth;
    } rec_t;

    typedef struct packed {
        logic [FID_W-1:0] fid;
        logic [TS_W-1:0]  enter;
    } frame_t;

endpackage

// ===== src/cstp_if.sv =====
// Handshake channels of the profiler: event input and result output.
// Depends on cstp_pkg for the field widths.
`timescale 1ns / 1ps

interface cstp_in_if;
    logic                         valid;
    logic                         ready;
    logic [cstp_pkg::KIND_W-1:0]  kind;
    logic [cstp_pkg::FID_W-1:0]   function_id;
    logic [cstp_pkg::TS_W-1:0]    timestamp;

    modport source (output valid, kind, function_id, timestamp, input ready);
    modport sink   (input valid, kind, function_id, timestamp, output ready);
endinterface

interface cstp_out_if;
    logic                          valid;
    logic                          ready;
    logic [cstp_pkg::STATUS_W-1:0] status;
    logic [cstp_pkg::CALLS_W-1:0]  call_count;
    logic [cstp_pkg::TOTAL_W-1:0]  inclusive_total;
    logic [cstp_pkg::TOTAL_W-1:0]  exclusive_total;
    logic [cstp_pkg::DEPTH_W-1:0]  nesting_depth;
    logic [cstp_pkg::TS_W-1:0]     elapsed_ticks;
    logic [cstp_pkg::LEVEL_W-1:0]  stack_level;

    modport source (output valid, status, call_count, inclusive_total, exclusive_total,
                    nesting_depth, elapsed_ticks, stack_level, input ready);
    modport sink   (input valid, status, call_count, inclusive_total, exclusive_total,
                    nesting_depth, elapsed_ticks, stack_level, output ready);
endinterface

// ===== src/cstp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module cstp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/cstp_queue.sv =====
// Short FIFO between the profiler front end and back end.
// No dependencies.
`timescale 1ns / 1ps

module cstp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== src/cstp_front.sv =====
// Front end of the profiler: accept event items, classify them, map the slot.
// Depends on cstp_pkg and the cstp_in_if channel.
`timescale 1ns / 1ps

module cstp_front #(
    parameter int FUNCTION_SLOTS = 256
) (
    cstp_in_if.sink                           in_ch,
    input  logic                              capture_enable,
    input  logic                              init_busy,
    input  logic                              q_full,
    output logic                              push_valid,
    output cstp_pkg::op_t                     push_op,
    output logic [$clog2(FUNCTION_SLOTS)-1:0] push_slot
);
    import cstp_pkg::*;

    localparam int SLOT_W = $clog2(FUNCTION_SLOTS);

    // Slot of each function id, modulo the table size.
    logic [SLOT_W-1:0] slot_lut [FID_COUNT];

    for (genvar g = 0; g < FID_COUNT; g++)
    begin : g_slot
        assign slot_lut[g] = SLOT_W'(g % FUNCTION_SLOTS);
    end

    assign in_ch.ready = !q_full && !init_busy;
    assign push_valid  = in_ch.valid && in_ch.ready;
    assign push_slot   = slot_lut[in_ch.function_id];

    always_comb
    begin
        push_op.fid = in_ch.function_id;
        push_op.ts  = in_ch.timestamp;
        unique case (kind_t'(in_ch.kind))
            KIND_ENTER: push_op.cls = capture_enable ? CLS_ENTER : CLS_NOCAP;
            KIND_LEAVE: push_op.cls = capture_enable ? CLS_LEAVE : CLS_NOCAP;
            KIND_READ:  push_op.cls = CLS_READ;
            KIND_CLEAR: push_op.cls = CLS_CLEAR;
            default:    push_op.cls = CLS_READ;
        endcase
    end

endmodule

// ===== src/cstp_back.sv =====
// Back end of the profiler: shadow stack, per-function records, result register.
// Depends on cstp_pkg, cstp_ram and the cstp_out_if channel.
`timescale 1ns / 1ps

module cstp_back #(
    parameter int STACK_DEPTH    = 64,
    parameter int FUNCTION_SLOTS = 256
) (
    input  logic clk,
    input  logic rst_n,
    input  logic q_empty,
    input  logic [$bits(cstp_pkg::op_t)+$clog2(FUNCTION_SLOTS)-1:0] q_data,
    output logic q_pop,
    output logic init_busy,
    cstp_out_if.source out_ch
);
    import cstp_pkg::*;

    localparam int SLOT_W = $clog2(FUNCTION_SLOTS);
    localparam int SW     = $clog2(STACK_DEPTH);
    localparam int TW     = $clog2(STACK_DEPTH + 1);
    localparam int Q_W    = $bits(op_t) + SLOT_W;

    back_state_t state_reg, state_next;

    op_t               q_op;
    logic [SLOT_W-1:0] q_slot;

    logic              init_reg;
    logic [SLOT_W-1:0] sweep_reg;
    logic [TW-1:0]     top_reg;
    op_t               op_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [TS_W-1:0]   top_child_reg;
    logic [TS_W-1:0]   elapsed_reg;
    logic [TS_W-1:0]   excl_reg;
    logic [TS_W-1:0]   child_sum_reg;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    rec_t                out_rec_reg;
    logic [TS_W-1:0]     out_elapsed_reg;
    logic [LEVEL_W-1:0]  out_level_reg;

    rec_t              rec_rd;
    frame_t            frame_rd;
    logic [TS_W-1:0]   child_rd;

    logic              out_free;
    logic              exec_fire;
    logic              sweep_last;
    logic              rec_we;
    logic [SLOT_W-1:0] rec_waddr;
    rec_t              rec_wdata;
    logic              frame_we;
    logic              child_we;

    // Execute-step results
    status_t           ex_status;
    logic              ex_show;
    logic              ex_rec_wr;
    rec_t              ex_rec_new;
    rec_t              ex_rec_out;
    rec_t              ex_base;
    logic              ex_push;
    logic              ex_pop_match;
    logic              ex_pop_miss;
    logic [TS_W-1:0]   ex_elapsed;
    logic [TW-1:0]     ex_top_next;
    logic [TOTAL_W:0]  incl_sum;
    logic [TOTAL_W:0]  excl_sum;
    logic [TS_W:0]     child_sum;

    assign q_op   = q_data[Q_W-1:SLOT_W];
    assign q_slot = q_data[SLOT_W-1:0];

    assign init_busy  = init_reg;
    assign out_free   = !out_valid_reg || out_ch.ready;
    assign sweep_last = (sweep_reg == SLOT_W'(FUNCTION_SLOTS - 1));

    // ---------------- memories ----------------
    cstp_ram #(.WIDTH($bits(rec_t)), .DEPTH(FUNCTION_SLOTS)) u_rec_ram (
        .clk     (clk),
        .wr_en   (rec_we),
        .wr_addr (rec_waddr),
        .wr_data (rec_wdata),
        .rd_en   (q_pop),
        .rd_addr (q_slot),
        .rd_data (rec_rd)
    );

    cstp_ram #(.WIDTH($bits(frame_t)), .DEPTH(STACK_DEPTH)) u_frame_ram (
        .clk     (clk),
        .wr_en   (frame_we),
        .wr_addr (SW'(top_reg)),
        .wr_data ({op_reg.fid, op_reg.ts}),
        .rd_en   (q_pop),
        .rd_addr (SW'(top_reg - TW'(1))),
        .rd_data (frame_rd)
    );

    // Child time of each frame below the top; the top frame's lives in top_child_reg.
    cstp_ram #(.WIDTH(TS_W), .DEPTH(STACK_DEPTH)) u_child_ram (
        .clk     (clk),
        .wr_en   (child_we),
        .wr_addr (SW'(top_reg - TW'(1))),
        .wr_data (top_child_reg),
        .rd_en   (q_pop),
        .rd_addr (SW'(top_reg - TW'(2))),
        .rd_data (child_rd)
    );

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_SWEEP;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        exec_fire  = 1'b0;
        unique case (state_reg)
            BK_SWEEP:
            begin
                if (sweep_last)
                begin
                    state_next = init_reg ? BK_IDLE : BK_EXEC;
                end
            end
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    state_next = (q_op.cls == CLS_CLEAR) ? BK_SWEEP : BK_WAIT;
                end
            end
            BK_WAIT: state_next = BK_CALC;
            BK_CALC: state_next = BK_EXEC;
            BK_EXEC:
            begin
                if (out_free)
                begin
                    exec_fire  = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // ---------------- execute step ----------------
    assign incl_sum  = {1'b0, rec_rd.incl} + (TOTAL_W + 1)'(elapsed_reg);
    assign excl_sum  = {1'b0, rec_rd.excl} + (TOTAL_W + 1)'(excl_reg);
    assign child_sum = {1'b0, child_rd} + {1'b0, elapsed_reg};

    always_comb
    begin
        ex_status    = STAT_OK;
        ex_show      = 1'b1;
        ex_rec_wr    = 1'b0;
        ex_base      = rec_rd.valid ? rec_rd : '0;
        ex_rec_new   = rec_rd;
        ex_rec_out   = rec_rd;
        ex_push      = 1'b0;
        ex_pop_match = 1'b0;
        ex_pop_miss  = 1'b0;
        ex_elapsed   = '0;
        unique case (op_reg.cls)
            CLS_NOCAP: ex_status = STAT_NOT_CAPTURING;
            CLS_READ:  ex_status = STAT_OK;
            CLS_CLEAR: ex_show   = 1'b0;
            CLS_ENTER:
            begin
                if (top_reg == TW'(STACK_DEPTH))
                begin
                    ex_status = STAT_STACK_FULL;
                end
                else
                begin
                    ex_push          = 1'b1;
                    ex_rec_wr        = 1'b1;
                    ex_rec_new       = ex_base;
                    ex_rec_new.valid = 1'b1;
                    ex_rec_new.calls = (ex_base.calls == '1) ? ex_base.calls
                                                             : ex_base.calls + CALLS_W'(1);
                    ex_rec_new.depth = (ex_base.depth == DEPTH_MAX) ? DEPTH_MAX
                                                                   : ex_base.depth + DEPTH_W'(1);
                    ex_rec_out       = ex_rec_new;
                end
            end
            CLS_LEAVE:
            begin
                if (top_reg == '0)
                begin
                    ex_status = STAT_STACK_EMPTY;
                end
                else if (frame_rd.fid != op_reg.fid)
                begin
                    ex_status   = STAT_MISMATCH;
                    ex_pop_miss = 1'b1;
                end
                else
                begin
                    ex_pop_match = 1'b1;
                    ex_elapsed   = elapsed_reg;
                    if (rec_rd.valid)
                    begin
                        ex_rec_wr        = 1'b1;
                        ex_rec_new.incl  = incl_sum[TOTAL_W] ? '1 : incl_sum[TOTAL_W-1:0];
                        ex_rec_new.excl  = excl_sum[TOTAL_W] ? '1 : excl_sum[TOTAL_W-1:0];
                        ex_rec_new.depth = (rec_rd.depth != '0) ? rec_rd.depth - DEPTH_W'(1)
                                                                : rec_rd.depth;
                        ex_rec_out       = ex_rec_new;
                    end
                end
            end
            default: ex_show = 1'b0;
        endcase

        if (ex_push)
        begin
            ex_top_next = top_reg + TW'(1);
        end
        else if (ex_pop_match || ex_pop_miss)
        begin
            ex_top_next = top_reg - TW'(1);
        end
        else
        begin
            ex_top_next = top_reg;
        end
    end

    // Record RAM: cleared by the sweep, else written back by the execute step.
    always_comb
    begin
        if (state_reg == BK_SWEEP)
        begin
            rec_we    = 1'b1;
            rec_waddr = sweep_reg;
            rec_wdata = '0;
        end
        else
        begin
            rec_we    = exec_fire && ex_rec_wr;
            rec_waddr = slot_reg;
            rec_wdata = ex_rec_new;
        end
    end

    assign frame_we = exec_fire && ex_push;
    assign child_we = exec_fire && ex_push && (top_reg != '0);

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg      <= 1'b1;
            sweep_reg     <= '0;
            top_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == BK_SWEEP)
            begin
                sweep_reg <= sweep_reg + SLOT_W'(1);
                if (sweep_last)
                begin
                    init_reg <= 1'b0;
                end
            end
            if (q_pop && q_op.cls == CLS_CLEAR)
            begin
                sweep_reg <= '0;
                top_reg   <= '0;
            end
            if (exec_fire)
            begin
                top_reg       <= ex_top_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            op_reg   <= q_op;
            slot_reg <= q_slot;
        end
        if (state_reg == BK_WAIT)
        begin
            elapsed_reg <= op_reg.ts - frame_rd.enter;
        end
        if (state_reg == BK_CALC)
        begin
            excl_reg      <= (top_child_reg <= elapsed_reg) ? elapsed_reg - top_child_reg : '0;
            child_sum_reg <= child_sum[TS_W] ? '1 : child_sum[TS_W-1:0];
        end
        if (exec_fire)
        begin
            if (ex_push)
            begin
                top_child_reg <= '0;
            end
            else if (ex_pop_match)
            begin
                top_child_reg <= child_sum_reg;
            end
            else if (ex_pop_miss)
            begin
                top_child_reg <= child_rd;
            end
            out_status_reg  <= ex_status;
            out_rec_reg     <= (ex_show && ex_rec_out.valid) ? ex_rec_out : '0;
            out_elapsed_reg <= ex_elapsed;
            out_level_reg   <= LEVEL_W'(ex_top_next);
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.status          = out_status_reg;
    assign out_ch.call_count      = out_rec_reg.calls;
    assign out_ch.inclusive_total = out_rec_reg.incl;
    assign out_ch.exclusive_total = out_rec_reg.excl;
    assign out_ch.nesting_depth   = out_rec_reg.depth;
    assign out_ch.elapsed_ticks   = out_elapsed_reg;
    assign out_ch.stack_level     = out_level_reg;

    // ---------------- checks ----------------
    a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg <= TW'(STACK_DEPTH))
        else $error("stack pointer beyond stack depth");

    a_out_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == BK_EXEC))
        else $error("result loaded outside the execute step");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire && ex_push |=> top_reg == $past(top_reg) + TW'(1))
        else $error("push did not advance the stack pointer");

    a_hold_exec: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_EXEC && !out_free |=> state_reg == BK_EXEC)
        else $error("execute step left while the result register was busy");

endmodule

// ===== src/call_stack_time_profiler.sv =====
// Top level of the call-stack time profiler (shadow stack, per-function totals).
// The back end finishes one item (read, elapsed, exclusive, write-back of one record) before popping the next.
// A clear item sweeps the record RAM (one record cleared per cycle).
// Reset: async, active low; then a sweep of all records with input ready low.
// Depends on cstp_pkg, cstp_if, cstp_front, cstp_queue, cstp_back, cstp_ram.
`timescale 1ns / 1ps

module call_stack_time_profiler #(
    parameter int STACK_DEPTH    = 64,
    parameter int FUNCTION_SLOTS = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_write_en,
    input  logic          cfg_write_data,
    cstp_in_if.sink       in_ch,
    cstp_out_if.source    out_ch
);
    import cstp_pkg::*;

    localparam int SLOT_W = $clog2(FUNCTION_SLOTS);
    localparam int Q_W    = $bits(op_t) + SLOT_W;

    // Capture enable register; the user must write it only while the block is idle (not enforced by the block).
    logic capture_enable_reg;

    // Front end to queue
    logic              push_valid;
    op_t               push_op;
    logic [SLOT_W-1:0] push_slot;
    logic              q_full;

    // Queue to back end
    logic              q_pop;
    logic              q_empty;
    logic [Q_W-1:0]    q_data;
    logic              init_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capture_enable_reg <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            capture_enable_reg <= cfg_write_data;
        end
    end

    // Accept items, classify them against the capture enable, map the slot.
    cstp_front #(.FUNCTION_SLOTS(FUNCTION_SLOTS)) u_front (
        .in_ch          (in_ch),
        .capture_enable (capture_enable_reg),
        .init_busy      (init_busy),
        .q_full         (q_full),
        .push_valid     (push_valid),
        .push_op        (push_op),
        .push_slot      (push_slot)
    );

    // Hold classified items so the front keeps accepting while the back works.
    cstp_queue #(.WIDTH(Q_W), .DEPTH(2)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_valid),
        .push_data ({push_op, push_slot}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    // Stack and record updates, result register toward the sink.
    cstp_back #(
        .STACK_DEPTH    (STACK_DEPTH),
        .FUNCTION_SLOTS (FUNCTION_SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .init_busy (init_busy),
        .out_ch    (out_ch)
    );

endmodule

// ===== test/tb_top.sv =====
// Testbench of the call-stack time profiler: drives events, predicts every result, checks them.
// Depends on cstp_pkg, cstp_if and the call_stack_time_profiler RTL.
`timescale 1ns / 1ps

module tb_top;

    import cstp_pkg::*;

    localparam int STACK_DEPTH    = 64;
    localparam int FUNCTION_SLOTS = 256;
    localparam int CYCLE_LIMIT    = 500000;

    // One event as the sender sees it.
    typedef struct {
        kind_t            kind;
        logic [FID_W-1:0] fid;
        logic [TS_W-1:0]  ts;
    } prof_event_t;

    // One result as the block should report it.
    typedef struct {
        status_t             status;
        logic [CALLS_W-1:0]  calls;
        logic [TOTAL_W-1:0]  incl;
        logic [TOTAL_W-1:0]  excl;
        logic [DEPTH_W-1:0]  depth;
        logic [TS_W-1:0]     elapsed;
        logic [LEVEL_W-1:0]  level;
    } prof_result_t;

    logic clk;
    logic rst_n;
    logic cfg_write_en;
    logic cfg_write_data;

    cstp_in_if  in_ch ();
    cstp_out_if out_ch ();

    call_stack_time_profiler #(
        .STACK_DEPTH    (STACK_DEPTH),
        .FUNCTION_SLOTS (FUNCTION_SLOTS)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_ch          (in_ch),
        .out_ch         (out_ch)
    );

    // Events waiting to be sent, and results the block still owes us.
    prof_event_t  event_q[$];
    prof_result_t owed_results[$];

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned error_count;
    int unsigned result_index;
    int unsigned cycle_count;
    bit          in_taken;

    // Predicted state of the block: shadow stack, per-function records, capture register.
    bit                 capture_on;
    int                 stack_used;
    logic [FID_W-1:0]   frame_fid   [STACK_DEPTH];
    logic [TS_W-1:0]    frame_enter [STACK_DEPTH];
    logic [TS_W-1:0]    frame_child [STACK_DEPTH];
    bit                 rec_valid   [FUNCTION_SLOTS];
    logic [CALLS_W-1:0] rec_calls   [FUNCTION_SLOTS];
    logic [TOTAL_W-1:0] rec_incl    [FUNCTION_SLOTS];
    logic [TOTAL_W-1:0] rec_excl    [FUNCTION_SLOTS];
    logic [DEPTH_W-1:0] rec_depth   [FUNCTION_SLOTS];

    // Stimulus-side view of the stack, kept at generation time so that
    // leaves can name the function that is really on top.
    bit                 gen_capture;
    logic [FID_W-1:0]   gen_stack[$];
    logic [TS_W-1:0]    gen_time;
    logic [FID_W-1:0]   favorite_fids[8] = '{8'd0, 8'd1, 8'd2, 8'd3,
                                             8'd128, 8'd200, 8'd254, 8'd255};

    // Clock and reset: reset is held once, at the start.
    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Build a result: the record of the slot is shown only when asked and valid.
    function automatic prof_result_t make_result(status_t st, int unsigned slot, bit show,
                                                 logic [TS_W-1:0] span);
        prof_result_t res;
        res.status  = st;
        res.calls   = '0;
        res.incl    = '0;
        res.excl    = '0;
        res.depth   = '0;
        if (show && rec_valid[slot])
        begin
            res.calls = rec_calls[slot];
            res.incl  = rec_incl[slot];
            res.excl  = rec_excl[slot];
            res.depth = rec_depth[slot];
        end
        res.elapsed = span;
        res.level   = LEVEL_W'(stack_used);
        return res;
    endfunction

    // 48-bit total plus a 32-bit tick count, held at all ones on overflow.
    function automatic logic [TOTAL_W-1:0] add_sat_total(logic [TOTAL_W-1:0] a,
                                                         logic [TS_W-1:0] b);
        logic [TOTAL_W:0] sum;
        sum = a + b;
        return sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
    endfunction

    // Apply one accepted event to the predicted state and return its result.
    function automatic prof_result_t predict_event(kind_t kind, logic [FID_W-1:0] fid,
                                                   logic [TS_W-1:0] ts);
        int unsigned     slot;
        logic [TS_W-1:0] span;
        logic [TS_W-1:0] child;
        logic [TS_W-1:0] own;
        logic [TS_W:0]   wide;
        slot = fid % FUNCTION_SLOTS;

        // Read and clear work with capture on or off.
        if (kind == KIND_READ)
            return make_result(STAT_OK, slot, 1'b1, '0);
        if (kind == KIND_CLEAR)
        begin
            foreach (rec_valid[i])
                rec_valid[i] = 1'b0;
            stack_used = 0;
            return make_result(STAT_OK, slot, 1'b0, '0);
        end
        if (!capture_on)
            return make_result(STAT_NOT_CAPTURING, slot, 1'b1, '0);

        if (kind == KIND_ENTER)
        begin
            if (stack_used >= STACK_DEPTH)
                return make_result(STAT_STACK_FULL, slot, 1'b1, '0);
            frame_fid[stack_used]   = fid;
            frame_enter[stack_used] = ts;
            frame_child[stack_used] = '0;
            stack_used++;
            // First enter since reset or clear starts the record from zero.
            if (!rec_valid[slot])
            begin
                rec_valid[slot] = 1'b1;
                rec_calls[slot] = '0;
                rec_incl[slot]  = '0;
                rec_excl[slot]  = '0;
                rec_depth[slot] = '0;
            end
            if (rec_calls[slot] != {CALLS_W{1'b1}})
                rec_calls[slot] = rec_calls[slot] + 1'b1;
            if (rec_depth[slot] < DEPTH_MAX)
                rec_depth[slot] = rec_depth[slot] + 1'b1;
            return make_result(STAT_OK, slot, 1'b1, '0);
        end

        // Leave: pop the top frame even when it names another function.
        if (stack_used == 0)
            return make_result(STAT_STACK_EMPTY, slot, 1'b1, '0);
        stack_used--;
        if (frame_fid[stack_used] != fid)
            return make_result(STAT_MISMATCH, slot, 1'b1, '0);

        span  = ts - frame_enter[stack_used];
        child = frame_child[stack_used];
        own   = (child <= span) ? span - child : '0;
        if (rec_valid[slot])
        begin
            rec_incl[slot] = add_sat_total(rec_incl[slot], span);
            rec_excl[slot] = add_sat_total(rec_excl[slot], own);
            if (rec_depth[slot] > 0)
                rec_depth[slot] = rec_depth[slot] - 1'b1;
        end
        // Charge the closed activation to its caller, saturating.
        if (stack_used > 0)
        begin
            wide = frame_child[stack_used-1] + span;
            frame_child[stack_used-1] = wide[TS_W] ? {TS_W{1'b1}} : wide[TS_W-1:0];
        end
        return make_result(STAT_OK, slot, 1'b1, span);
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (error_count < 40)
            $display("mismatch at result %0d: %s got 0x%0h want 0x%0h",
                     result_index, what, got, want);
        error_count++;
    endtask

    // Sample both channels at the rising edge: predict on input accept,
    // compare on output accept, and watch the cycle budget.
    always @(posedge clk)
    begin : monitor
        prof_event_t  ev;
        prof_result_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
        else if (rst_n)
        begin
            in_taken = in_ch.valid && in_ch.ready;
            if (in_taken)
            begin
                ev = event_q.pop_front();
                owed_results.insert(owed_results.size(),
                                    predict_event(ev.kind, ev.fid, ev.ts));
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (owed_results.size() == 0)
                    report_mismatch("unexpected result, status", out_ch.status, '0);
                else
                begin
                    want = owed_results.pop_front();
                    if (out_ch.status !== want.status)
                        report_mismatch("status", out_ch.status, want.status);
                    if (out_ch.call_count !== want.calls)
                        report_mismatch("call_count", out_ch.call_count, want.calls);
                    if (out_ch.inclusive_total !== want.incl)
                        report_mismatch("inclusive_total", out_ch.inclusive_total, want.incl);
                    if (out_ch.exclusive_total !== want.excl)
                        report_mismatch("exclusive_total", out_ch.exclusive_total, want.excl);
                    if (out_ch.nesting_depth !== want.depth)
                        report_mismatch("nesting_depth", out_ch.nesting_depth, want.depth);
                    if (out_ch.elapsed_ticks !== want.elapsed)
                        report_mismatch("elapsed_ticks", out_ch.elapsed_ticks, want.elapsed);
                    if (out_ch.stack_level !== want.level)
                        report_mismatch("stack_level", out_ch.stack_level, want.level);
                end
                result_index++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: change inputs at the falling edge only
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (!rst_n)
            in_ch.valid <= 1'b0;
        else if (in_ch.valid && !in_taken)
        begin
            // Hold the item until the block takes it.
        end
        else if (event_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
        begin
            in_ch.valid       <= 1'b1;
            in_ch.kind        <= event_q[0].kind;
            in_ch.function_id <= event_q[0].fid;
            in_ch.timestamp   <= event_q[0].ts;
        end
        else
            in_ch.valid <= 1'b0;
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    task automatic queue_event(kind_t kind, logic [FID_W-1:0] fid, logic [TS_W-1:0] ts);
        prof_event_t ev;
        ev.kind = kind;
        ev.fid  = fid;
        ev.ts   = ts;
        event_q.insert(event_q.size(), ev);
    endtask

    // Wait until nothing is queued, in flight or owed, then let the block settle.
    task automatic wait_drained(int unsigned settle);
        while (event_q.size() != 0 || in_ch.valid || owed_results.size() != 0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
        @(posedge clk);
        #1;
    endtask

    // Write the capture register; only called while the block is drained.
    task automatic write_capture(bit value);
        @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(negedge clk);
        cfg_write_en   <= 1'b0;
        capture_on  = value;
        gen_capture = value;
        @(posedge clk);
        #1;
    endtask

    function automatic logic [FID_W-1:0] pick_fid();
        if ($urandom_range(99) < 70)
            return favorite_fids[$urandom_range(0, 7)];
        return FID_W'($urandom_range(0, 255));
    endfunction

    // Random events. With capture on, mostly balanced enter/leave nesting with
    // an opening dive past the stack limit; with capture off, plain noise.
    task automatic fill_random(int n_items);
        int               idx;
        int               dive;
        int unsigned      enter_pct;
        int unsigned      r;
        kind_t            kind;
        logic [FID_W-1:0] fid;
        dive      = gen_capture ? STACK_DEPTH + 6 : 0;
        enter_pct = 45;
        for (idx = 0; idx < n_items; idx++)
        begin
            if (idx % 40 == 0)
                enter_pct = $urandom_range(25, 65);
            // Advance the time base: mostly short steps, sometimes long, sometimes a jump.
            r = $urandom_range(99);
            if (r < 80)
                gen_time = gen_time + $urandom_range(1, 1000);
            else if (r < 95)
                gen_time = gen_time + $urandom_range(0, 100000);
            else
                gen_time = $urandom();

            if (!gen_capture)
            begin
                kind = kind_t'($urandom_range(0, 3));
                if (kind == KIND_CLEAR && $urandom_range(3) != 0)
                    kind = KIND_READ;
                fid = FID_W'($urandom_range(0, 255));
                if (kind == KIND_CLEAR)
                    gen_stack.delete();
            end
            else if (dive > 0)
            begin
                kind = KIND_ENTER;
                fid  = FID_W'($urandom_range(0, 255));
                dive--;
            end
            else
            begin
                r = $urandom_range(99);
                if (r < enter_pct)
                begin
                    kind = KIND_ENTER;
                    fid  = pick_fid();
                end
                else if (r < 88)
                begin
                    kind = KIND_LEAVE;
                    fid  = (gen_stack.size() > 0) ? gen_stack[$] : pick_fid();
                end
                else if (r < 93)
                begin
                    kind = KIND_LEAVE;
                    fid  = (gen_stack.size() > 0)
                           ? gen_stack[$] ^ FID_W'($urandom_range(1, 255)) : pick_fid();
                end
                else if (r < 98)
                begin
                    kind = KIND_READ;
                    fid  = (gen_stack.size() > 0 && r < 96) ? gen_stack[$] : pick_fid();
                end
                else
                begin
                    kind = KIND_CLEAR;
                    fid  = FID_W'($urandom_range(0, 255));
                end
            end

            // Track the stack as the block will see it.
            if (gen_capture)
            begin
                if (kind == KIND_ENTER && gen_stack.size() < STACK_DEPTH)
                    gen_stack.insert(gen_stack.size(), fid);
                else if (kind == KIND_LEAVE && gen_stack.size() > 0)
                    gen_stack.delete(gen_stack.size() - 1);
                else if (kind == KIND_CLEAR)
                    gen_stack.delete();
            end
            queue_event(kind, fid, gen_time);
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_write_en    = 1'b0;
        cfg_write_data  = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.kind        = '0;
        in_ch.function_id = '0;
        in_ch.timestamp   = '0;
        out_ch.ready      = 1'b0;
        capture_on      = 1'b0;
        gen_capture     = 1'b0;
        stack_used      = 0;
        error_count     = 0;
        result_index    = 0;
        cycle_count     = 0;
        in_taken        = 1'b0;
        gen_time        = '0;
        send_idle_pct   = 15;
        recv_idle_pct   = 63;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        #1;

        // Capture off after reset: enter and leave are refused, read and clear work.
        queue_event(KIND_ENTER, 8'd0,   32'h0000_0000);
        queue_event(KIND_LEAVE, 8'd255, 32'hFFFF_FFFF);
        queue_event(KIND_READ,  8'd7,   32'h0000_0000);
        queue_event(KIND_CLEAR, 8'd255, 32'h0000_0000);
        wait_drained(8);
        write_capture(1'b1);

        // Leave on an empty stack.
        queue_event(KIND_LEAVE, 8'd3,   32'd100);
        // Nested calls: timestamp wrap, full-range elapsed, child time saturating
        // and then exceeding the caller's own elapsed time.
        queue_event(KIND_ENTER, 8'd0,   32'h0000_0000);
        queue_event(KIND_ENTER, 8'd255, 32'hFFFF_FFF0);
        queue_event(KIND_LEAVE, 8'd255, 32'h0000_0010);
        queue_event(KIND_READ,  8'd0,   32'h0000_0000);
        queue_event(KIND_ENTER, 8'd1,   32'd5);
        queue_event(KIND_LEAVE, 8'd1,   32'd4);
        queue_event(KIND_ENTER, 8'd2,   32'h0000_0000);
        queue_event(KIND_LEAVE, 8'd2,   32'hFFFF_FFFF);
        queue_event(KIND_LEAVE, 8'd0,   32'd10);
        // Mismatched leave pops the frame but leaves the record alone.
        queue_event(KIND_ENTER, 8'd5,   32'd20);
        queue_event(KIND_LEAVE, 8'd6,   32'd30);
        queue_event(KIND_READ,  8'd5,   32'd0);
        queue_event(KIND_ENTER, 8'd5,   32'd40);
        queue_event(KIND_LEAVE, 8'd5,   32'd50);
        queue_event(KIND_READ,  8'd255, 32'd0);
        // Clear with capture on, then a record restarting from zero.
        queue_event(KIND_CLEAR, 8'd0,   32'd0);
        queue_event(KIND_READ,  8'd0,   32'd0);
        queue_event(KIND_ENTER, 8'd0,   32'd60);
        queue_event(KIND_LEAVE, 8'd0,   32'd61);
        gen_time = 32'd100;

        // Sender idles lightly, receiver stalls often.
        fill_random(400);
        wait_drained(8);

        // Swap the idling; capture off for a stretch of noise.
        send_idle_pct = 63;
        recv_idle_pct = 15;
        write_capture(1'b0);
        fill_random(80);
        wait_drained(8);
        write_capture(1'b1);
        fill_random(350);
        wait_drained(8);

        // No idling on either side.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fill_random(400);
        wait_drained(8);
        write_capture(1'b0);
        fill_random(40);

        // Drain, then give a trailing clear time to finish before the verdict.
        wait_drained(FUNCTION_SLOTS + 16);
        if (owed_results.size() != 0)
            report_mismatch("results never arrived, count", owed_results.size(), '0);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
src/cstp_pkg.sv
src/cstp_if.sv
src/cstp_ram.sv
src/cstp_queue.sv
src/cstp_front.sv
src/cstp_back.sv
src/call_stack_time_profiler.sv
test/tb_top.sv
